/* src/union_find_connectivity_defines.svh */
// ----------------------------------------------------------------------------
// Union-find connectivity: assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_CONNECTIVITY_DEFINES_SVH
`define UNION_FIND_CONNECTIVITY_DEFINES_SVH

// same-cycle implication
`define UFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UFC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ufc_pkg.sv */
// ----------------------------------------------------------------------------
// Union-find connectivity: package
// Field widths, register map and reset constants.
// ----------------------------------------------------------------------------
package ufc_pkg;

	localparam int MAX_NODES_DEF  = 1024;
	localparam int NODE_COUNT_RST = 1024;

	localparam int NODE_W     = 10;
	localparam int CNT_W      = 11;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register select, paddr[2]
	localparam logic REG_NODE_COUNT = 1'b0;

endpackage

/* src/union_find_connectivity.sv */
// ----------------------------------------------------------------------------
// Union-find connectivity
// Disjoint-set engine, union by size with two-pass path compression.
// ----------------------------------------------------------------------------
// Each item is an edge (node_a, node_b). A small sequencer drives one parent
// memory and one size memory, each with one registered read port and one write
// port: it walks from node_a to its root at one link per cycle, repoints that
// path at the root one node per cycle, does the same for node_b, then links the
// smaller root under the larger, writing the parent first and the size after.
// An edge with an endpoint not below node_count goes straight to the result
// with merged low. A full result register holds the sequencer in its last
// state until the waiting result is taken. After reset and after every
// node_count write the block runs a clearing pass, one entry per cycle, over
// all MAX_NODES entries, and takes no item until it ends. One result register
// lets the next item enter while a result waits.

`include "union_find_connectivity_defines.svh"

module union_find_connectivity import ufc_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [NODE_W-1:0]     node_a,
	input  logic [NODE_W-1:0]     node_b,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  merged,
	output logic [CNT_W-1:0]      component_count,
	output logic                  all_connected
);

	localparam int NW        = $clog2(MAX_NODES);
	localparam int CW        = $clog2(MAX_NODES + 1);
	localparam int CMP_W     = (CW > CNT_W) ? CW : CNT_W;
	localparam int RST_COUNT = (NODE_COUNT_RST > MAX_NODES) ? MAX_NODES : NODE_COUNT_RST;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FA, ST_CA, ST_FB_RD, ST_FB, ST_CB,
		ST_JOIN, ST_LINK1, ST_LINK2, ST_DONE
	} state_t;

	state_t st_q;

	logic [NW-1:0] clr_q;
	logic [CW-1:0] node_count_q;
	logic [CW-1:0] live_q;
	logic [NW-1:0] a_q, b_q, cur_q, ra_q, rb_q;
	logic [CW-1:0] sa_q, sb_q;
	logic          merged_q;

	logic          out_valid_q;
	logic          out_merged_q;
	logic [CW-1:0] out_count_q;
	logic          out_all_q;

	logic [NW-1:0] par_mem [MAX_NODES];
	logic [CW-1:0] sz_mem  [MAX_NODES];
	logic [NW-1:0] rd_par_q;
	logic [CW-1:0] rd_sz_q;

	logic [NW-1:0] rd_addr, wr_addr, wr_par;
	logic [CW-1:0] wr_sz;
	logic          par_we, sz_we;

	logic             cfg_hit;
	logic [CMP_W-1:0] wr_val;
	logic [CW-1:0]    wr_sat;
	logic             in_ok;
	logic             out_free;
	logic             load_out;
	logic             a_smaller;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_q) : '0;
	assign cfg_hit  = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
	assign wr_val   = CMP_W'(pwdata[CNT_W-1:0]);

	always_comb begin
		if (wr_val == '0) begin
			wr_sat = CW'(1);
		end else if (wr_val > CMP_W'(MAX_NODES)) begin
			wr_sat = CW'(MAX_NODES);
		end else begin
			wr_sat = CW'(wr_val);
		end
	end

	assign in_ready  = (st_q == ST_IDLE) && !cfg_hit;
	assign in_ok     = (CMP_W'(node_a) < CMP_W'(node_count_q)) &&
			   (CMP_W'(node_b) < CMP_W'(node_count_q));
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (st_q == ST_DONE) && out_free;
	assign a_smaller = (sa_q < sb_q);

	assign out_valid       = out_valid_q;
	assign merged          = out_merged_q;
	assign component_count = CNT_W'(out_count_q);
	assign all_connected   = out_all_q;

	// memory port control
	always_comb begin
		rd_addr = cur_q;
		wr_addr = cur_q;
		wr_par  = ra_q;
		wr_sz   = CW'(1);
		par_we  = 1'b0;
		sz_we   = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				par_we  = 1'b1;
				sz_we   = 1'b1;
				wr_addr = clr_q;
				wr_par  = clr_q;
			end
			ST_IDLE: begin
				rd_addr = NW'(node_a);
			end
			ST_FA: begin
				rd_addr = (rd_par_q == cur_q) ? a_q : rd_par_q;
			end
			ST_CA: begin
				par_we  = 1'b1;
				wr_par  = ra_q;
				rd_addr = rd_par_q;
			end
			ST_FB_RD: begin
				rd_addr = b_q;
			end
			ST_FB: begin
				rd_addr = (rd_par_q == cur_q) ? b_q : rd_par_q;
			end
			ST_CB: begin
				par_we  = 1'b1;
				wr_par  = rb_q;
				rd_addr = rd_par_q;
			end
			ST_LINK1: begin
				par_we  = 1'b1;
				wr_addr = a_smaller ? ra_q : rb_q;
				wr_par  = a_smaller ? rb_q : ra_q;
			end
			ST_LINK2: begin
				sz_we   = 1'b1;
				wr_addr = a_smaller ? rb_q : ra_q;
				wr_sz   = CW'(sa_q + sb_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[wr_addr] <= wr_par;
		end
		if (sz_we) begin
			sz_mem[wr_addr] <= wr_sz;
		end
		rd_par_q <= par_mem[rd_addr];
		rd_sz_q  <= sz_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			clr_q        <= '0;
			node_count_q <= CW'(RST_COUNT);
			live_q       <= CW'(RST_COUNT);
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_merged_q <= merged_q;
				out_count_q  <= live_q;
				out_all_q    <= (live_q == CW'(1));
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				node_count_q <= wr_sat;
				live_q       <= wr_sat;
				clr_q        <= '0;
				st_q         <= ST_CLEAR;
			end else begin
				case (st_q)
					ST_CLEAR: begin
						clr_q <= clr_q + NW'(1);
						if (clr_q == NW'(MAX_NODES - 1)) begin
							st_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_valid) begin
							a_q   <= NW'(node_a);
							b_q   <= NW'(node_b);
							cur_q <= NW'(node_a);
							if (in_ok) begin
								st_q <= ST_FA;
							end else begin
								merged_q <= 1'b0;
								st_q     <= ST_DONE;
							end
						end
					end
					ST_FA: begin
						if (rd_par_q == cur_q) begin
							ra_q <= cur_q;
							sa_q <= rd_sz_q;
							if (a_q == cur_q) begin
								cur_q <= b_q;
								st_q  <= ST_FB_RD;
							end else begin
								cur_q <= a_q;
								st_q  <= ST_CA;
							end
						end else begin
							cur_q <= rd_par_q;
						end
					end
					ST_CA: begin
						if (rd_par_q == ra_q) begin
							cur_q <= b_q;
							st_q  <= ST_FB_RD;
						end else begin
							cur_q <= rd_par_q;
						end
					end
					ST_FB_RD: begin
						st_q <= ST_FB;
					end
					ST_FB: begin
						if (rd_par_q == cur_q) begin
							rb_q  <= cur_q;
							sb_q  <= rd_sz_q;
							cur_q <= b_q;
							st_q  <= (b_q == cur_q) ? ST_JOIN : ST_CB;
						end else begin
							cur_q <= rd_par_q;
						end
					end
					ST_CB: begin
						if (rd_par_q == rb_q) begin
							st_q <= ST_JOIN;
						end else begin
							cur_q <= rd_par_q;
						end
					end
					ST_JOIN: begin
						if (ra_q == rb_q) begin
							merged_q <= 1'b0;
							st_q     <= ST_DONE;
						end else begin
							st_q <= ST_LINK1;
						end
					end
					ST_LINK1: begin
						st_q <= ST_LINK2;
					end
					ST_LINK2: begin
						if (live_q > CW'(1)) begin
							live_q <= live_q - CW'(1);
						end
						merged_q <= 1'b1;
						st_q     <= ST_DONE;
					end
					ST_DONE: begin
						if (out_free) begin
							st_q <= ST_IDLE;
						end
					end
					default: begin
						st_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	`UFC_ASSERT_IMP(a_live_range, 1'b1, (live_q >= CW'(1)) && (live_q <= node_count_q), "live count out of range")
	`UFC_ASSERT_NXT(a_link_dec, (st_q == ST_LINK2) && !cfg_hit, (live_q == $past(live_q) - CW'(1)) || ($past(live_q) == CW'(1)), "merge did not drop count")
	`UFC_ASSERT_NXT(a_cfg_clear, cfg_hit, (st_q == ST_CLEAR) && (clr_q == '0) && !in_ready, "node_count write did not restart clear")

endmodule
